>>> hdl/rsp_pkg.sv
// ----------------------------------------------------------------------------
// rsp_pkg
// Shared types and constants of the rain and snow particle projector.
// ----------------------------------------------------------------------------
package rsp_pkg;

  localparam int MAX_COLUMNS_DEF = 1024;
  localparam int NUM_W           = 32;
  localparam int Z_W             = 21;
  localparam int QDEPTH          = 4;
  localparam int CFG_W           = 21;

  localparam logic [12:0] WRAP_CENTER = 13'h1fff;
  localparam logic [5:0]  SHADE_MAX   = 6'd13;
  localparam logic [3:0]  SHADE_NEAR  = 4'd10;
  localparam logic [4:0]  COLOR_BASE  = 5'd15;

  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_RAIN = 2'd1,
    MODE_SNOW = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    CFG_CAM_X      = 3'd0,
    CFG_CAM_Z      = 3'd1,
    CFG_VIEW_COS   = 3'd2,
    CFG_VIEW_SIN   = 3'd3,
    CFG_FALL       = 3'd4,
    CFG_HEIGHT_NUM = 3'd5,
    CFG_VIEW_W     = 3'd6,
    CFG_VIEW_H     = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    mode_t       mode;
    logic [9:0]  column;
    logic [14:0] wall;
    logic        xneg;
    logic        yneg;
    logic [3:0]  shade;
    logic        keep;
  } tag_t;

  typedef struct packed {
    logic       snow;
    logic       near;
    logic       three;
    logic [9:0] xx;
    logic [9:0] yy;
    logic [3:0] shade;
  } pix_t;

  typedef struct packed {
    logic vld;
    pix_t pix;
  } q_push_t;

endpackage

>>> hdl/rsp_ram.sv
// ----------------------------------------------------------------------------
// rsp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rsp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/rsp_div.sv
// ----------------------------------------------------------------------------
// rsp_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rsp_div #(
  parameter int NW = 32,
  parameter int DW = 21
) (
  input  logic          clk,
  input  logic          adv,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo
);

  logic [DW-1:0] rem_r [NW];
  logic [NW-1:0] num_r [NW];
  logic [DW-1:0] den_r [NW];

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [NW-1:0] num_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW-1:0] rem_nxt;
    logic [NW-1:0] num_nxt;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num;
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign num_in = num_r[s-1];
      assign den_in = den_r[s-1];
    end

    always_comb begin
      trial   = {rem_in, num_in[NW-1]};
      diff    = trial - {1'b0, den_in};
      ge      = (trial >= {1'b0, den_in});
      rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
      num_nxt = {num_in[NW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[s] <= rem_nxt;
        num_r[s] <= num_nxt;
        den_r[s] <= den_in;
      end
    end
  end

  assign quo = num_r[NW-1];

endmodule

>>> hdl/rsp_front.sv
// ----------------------------------------------------------------------------
// rsp_front
// Settings, rotation, projection dividers, wall store, culling and occlusion.
// ----------------------------------------------------------------------------
module rsp_front import rsp_pkg::*; #(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  input  logic [1:0]       in_mode,
  input  logic [9:0]       in_column,
  input  logic [14:0]      in_wall_height,
  input  logic [13:0]      in_point_x_low,
  input  logic [13:0]      in_point_z_low,
  input  logic [9:0]       in_point_y_low,
  input  logic             q_full,
  output q_push_t          push
);

  localparam int AW = $clog2(MAX_COLUMNS);

  logic                adv;

  logic [13:0]         cam_x_r;
  logic [13:0]         cam_z_r;
  logic signed [17:0]  cos_r;
  logic signed [17:0]  sin_r;
  logic [15:0]         fall_r;
  logic [20:0]         hnum_r;
  logic [10:0]         vw_r;
  logic [10:0]         vh_r;

  assign adv = !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r <= '0;
      cam_z_r <= '0;
      cos_r   <= 18'sd65536;
      sin_r   <= '0;
      fall_r  <= '0;
      hnum_r  <= '0;
      vw_r    <= 11'd320;
      vh_r    <= 11'd160;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CAM_X:      cam_x_r <= cfg_data[13:0];
        CFG_CAM_Z:      cam_z_r <= cfg_data[13:0];
        CFG_VIEW_COS:   cos_r   <= $signed(cfg_data[17:0]);
        CFG_VIEW_SIN:   sin_r   <= $signed(cfg_data[17:0]);
        CFG_FALL:       fall_r  <= cfg_data[15:0];
        CFG_HEIGHT_NUM: hnum_r  <= cfg_data[20:0];
        CFG_VIEW_W:     vw_r    <= cfg_data[10:0];
        CFG_VIEW_H:     vh_r    <= cfg_data[10:0];
        default:        cam_x_r <= cam_x_r;
      endcase
    end
  end

  // stage a: wrap around camera
  logic               a_vld_r;
  mode_t              a_mode_r;
  logic [9:0]         a_col_r;
  logic [14:0]        a_wall_r;
  logic signed [14:0] a_ax_r;
  logic signed [14:0] a_az_r;
  logic [15:0]        a_ym_r;
  logic [13:0]        sx;
  logic [13:0]        sz;
  logic signed [14:0] ax_nxt;
  logic signed [14:0] az_nxt;
  logic [15:0]        ym_nxt;

  always_comb begin
    sx     = in_point_x_low + cam_x_r;
    sz     = in_point_z_low + cam_z_r;
    ax_nxt = $signed({2'b0, WRAP_CENTER}) - $signed({1'b0, sx});
    az_nxt = $signed({2'b0, WRAP_CENTER}) - $signed({1'b0, sz});
    ym_nxt = {in_point_y_low, 6'b0} + fall_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_mode_r <= mode_t'(in_mode);
      a_col_r  <= in_column;
      a_wall_r <= in_wall_height;
      a_ax_r   <= ax_nxt;
      a_az_r   <= az_nxt;
      a_ym_r   <= ym_nxt;
    end
  end

  // stage b: rotation products
  logic               b_vld_r;
  mode_t              b_mode_r;
  logic [9:0]         b_col_r;
  logic [14:0]        b_wall_r;
  logic signed [32:0] b_pxc_r;
  logic signed [32:0] b_pzs_r;
  logic signed [32:0] b_pzc_r;
  logic signed [32:0] b_pxs_r;
  logic signed [29:0] b_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (adv) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_mode_r <= a_mode_r;
      b_col_r  <= a_col_r;
      b_wall_r <= a_wall_r;
      b_pxc_r  <= a_ax_r * cos_r;
      b_pzs_r  <= a_az_r * sin_r;
      b_pzc_r  <= a_az_r * cos_r;
      b_pxs_r  <= a_ax_r * sin_r;
      b_y_r    <= $signed({3'b0, a_ym_r, 11'b0}) - $signed({2'b0, hnum_r, 7'b0});
    end
  end

  // stage c: sums, depth culling, magnitudes
  logic               c_vld_r;
  tag_t               c_tag_r;
  logic [NUM_W-1:0]   c_xmag_r;
  logic [NUM_W-1:0]   c_ymag_r;
  logic [Z_W-1:0]     c_z_r;
  logic signed [33:0] xsum;
  logic signed [33:0] wsum;
  logic [31:0]        xw;
  logic [31:0]        ww;
  logic [31:0]        xneg_val;
  logic signed [29:0] yneg_val;
  tag_t               c_tag_nxt;

  always_comb begin
    xsum     = 34'(b_pxc_r) + 34'(b_pzs_r);
    wsum     = 34'(b_pzc_r) - 34'(b_pxs_r);
    xw       = xsum[31:0];
    ww       = wsum[31:0];
    xneg_val = -xw;
    yneg_val = -b_y_r;
    c_tag_nxt.mode   = b_mode_r;
    c_tag_nxt.column = b_col_r;
    c_tag_nxt.wall   = b_wall_r;
    c_tag_nxt.xneg   = xw[31];
    c_tag_nxt.yneg   = b_y_r[29];
    c_tag_nxt.shade  = ww[28:25];
    c_tag_nxt.keep   = !ww[31] && (ww[30:8] != '0) && (ww[30:25] <= SHADE_MAX);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (adv) begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_tag_r  <= c_tag_nxt;
      c_xmag_r <= xw[31] ? xneg_val : xw;
      c_ymag_r <= NUM_W'(b_y_r[29] ? unsigned'(yneg_val) : unsigned'(b_y_r));
      c_z_r    <= ww[28:8];
    end
  end

  // dividers and side band
  logic [NUM_W-1:0] qx;
  logic [NUM_W-1:0] qy;
  logic [NUM_W-1:0] qh;
  logic [NUM_W-1:0] hnum_ext;

  assign hnum_ext = NUM_W'({hnum_r, 10'b0});

  rsp_div #(.NW(NUM_W), .DW(Z_W)) u_div_x (
    .clk(clk), .adv(adv), .num(c_xmag_r), .den(c_z_r), .quo(qx)
  );
  rsp_div #(.NW(NUM_W), .DW(Z_W)) u_div_y (
    .clk(clk), .adv(adv), .num(c_ymag_r), .den(c_z_r), .quo(qy)
  );
  rsp_div #(.NW(NUM_W), .DW(Z_W)) u_div_h (
    .clk(clk), .adv(adv), .num(hnum_ext), .den(c_z_r), .quo(qh)
  );

  logic [NUM_W-1:0] sb_vld_r;
  tag_t             sb_tag_r [NUM_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_vld_r <= '0;
    end else if (adv) begin
      sb_vld_r <= {sb_vld_r[NUM_W-2:0], c_vld_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb_tag_r[0] <= c_tag_r;
      for (int i = 1; i < NUM_W; i++) begin
        sb_tag_r[i] <= sb_tag_r[i-1];
      end
    end
  end

  // stage d: screen position, wall store access
  tag_t               e_tag;
  logic               e_vld;
  logic signed [33:0] xs;
  logic signed [33:0] xx;
  logic signed [33:0] act;
  logic signed [33:0] yy;
  logic               xok;
  logic               yok;
  logic               ram_we;
  logic [15:0]        ram_rdata;

  assign e_tag = sb_tag_r[NUM_W-1];
  assign e_vld = sb_vld_r[NUM_W-1];

  always_comb begin
    xs  = e_tag.xneg ? -$signed({2'b0, qx}) : $signed({2'b0, qx});
    xx  = xs + $signed({24'b0, vw_r[10:1]});
    act = e_tag.yneg ? -$signed({2'b0, qy}) : $signed({2'b0, qy});
    yy  = $signed({24'b0, vh_r[10:1]}) - act;
    xok = !xx[33] && (xx < $signed({23'b0, vw_r}));
    yok = !yy[33] && (yy != '0) && (yy < $signed({23'b0, vh_r}));
  end

  assign ram_we = adv && e_vld && (e_tag.mode == MODE_LOAD) &&
                  ({22'b0, e_tag.column} < 32'(MAX_COLUMNS));

  rsp_ram #(.WIDTH(16), .DEPTH(MAX_COLUMNS)) u_wall_ram (
    .clk(clk),
    .we(ram_we),
    .waddr(AW'(e_tag.column)),
    .wdata({1'b0, e_tag.wall}),
    .re(adv),
    .raddr(AW'(xx[10:0])),
    .rdata(ram_rdata)
  );

  logic             d_vld_r;
  mode_t            d_mode_r;
  logic             d_keep_r;
  logic             d_incol_r;
  logic             d_three_r;
  logic             d_xnz_r;
  logic [3:0]       d_shade_r;
  logic [9:0]       d_xx_r;
  logic [9:0]       d_yy_r;
  logic [NUM_W-1:0] d_qy_r;
  logic [NUM_W-1:0] d_qh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (adv) begin
      d_vld_r <= e_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_mode_r  <= e_tag.mode;
      d_keep_r  <= e_tag.keep && xok && yok;
      d_incol_r <= ({21'b0, xx[10:0]} < 32'(MAX_COLUMNS));
      d_three_r <= (yy > 34'sd2);
      d_xnz_r   <= (xx != '0);
      d_shade_r <= e_tag.shade;
      d_xx_r    <= xx[9:0];
      d_yy_r    <= yy[9:0];
      d_qy_r    <= qy;
      d_qh_r    <= qh;
    end
  end

  // occlusion and hand-off to the queue
  logic [15:0] wh;
  logic        occ;
  logic        shape_ok;

  always_comb begin
    wh       = d_incol_r ? ram_rdata : '0;
    occ      = (d_qy_r < NUM_W'(wh[15:3])) && (d_qh_r < NUM_W'(wh));
    shape_ok = (d_mode_r == MODE_RAIN) || ((d_mode_r == MODE_SNOW) && d_xnz_r);
    push.vld       = adv && d_vld_r && d_keep_r && !occ && shape_ok;
    push.pix.snow  = (d_mode_r == MODE_SNOW);
    push.pix.near  = (d_shade_r < SHADE_NEAR);
    push.pix.three = d_three_r;
    push.pix.xx    = d_xx_r;
    push.pix.yy    = d_yy_r;
    push.pix.shade = d_shade_r;
  end

endmodule

>>> hdl/rsp_back.sv
// ----------------------------------------------------------------------------
// rsp_back
// Point queue and pixel emitter with registered output.
// ----------------------------------------------------------------------------
module rsp_back import rsp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  q_push_t    push,
  output logic       q_full,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [9:0] out_pixel_x,
  output logic [9:0] out_pixel_y,
  output logic [4:0] out_color,
  output logic       out_last
);

  localparam int QAW = $clog2(QDEPTH);

  pix_t           q_r [QDEPTH];
  logic [QAW-1:0] wp_r;
  logic [QAW-1:0] rp_r;
  logic [QAW:0]   cnt_r;
  logic [1:0]     idx_r;

  logic           out_vld_r;
  logic [9:0]     px_r;
  logic [9:0]     py_r;
  logic [4:0]     col_r;
  logic           last_r;

  pix_t           head;
  logic [1:0]     nlast;
  logic           load_out;
  logic           step;
  logic           pop;
  logic [9:0]     px_nxt;
  logic [9:0]     py_nxt;
  logic [4:0]     col_nxt;

  assign q_full   = (cnt_r == (QAW+1)'(QDEPTH));
  assign head     = q_r[rp_r];
  assign load_out = !out_vld_r || !out_stall;
  assign step     = load_out && (cnt_r != '0);
  assign pop      = step && (idx_r == nlast);

  always_comb begin
    if (head.snow) begin
      nlast = head.near ? 2'd3 : 2'd0;
    end else begin
      nlast = head.three ? 2'd2 : 2'd1;
    end
    if (!head.snow) begin
      px_nxt  = head.xx;
      py_nxt  = head.yy - 10'(idx_r);
      col_nxt = COLOR_BASE + 5'(head.shade) + 5'(idx_r);
    end else if (head.near) begin
      px_nxt  = head.xx - 10'(idx_r[0]);
      py_nxt  = head.yy - 10'(idx_r[1]);
      col_nxt = COLOR_BASE + 5'd2 + 5'(head.shade) - 5'(idx_r[0]) - 5'(idx_r[1]);
    end else begin
      px_nxt  = head.xx;
      py_nxt  = head.yy;
      col_nxt = COLOR_BASE + 5'(head.shade);
    end
  end

  always_ff @(posedge clk) begin
    if (push.vld) begin
      q_r[wp_r] <= push.pix;
    end
    if (step) begin
      px_r   <= px_nxt;
      py_r   <= py_nxt;
      col_r  <= col_nxt;
      last_r <= (idx_r == nlast);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r      <= '0;
      rp_r      <= '0;
      cnt_r     <= '0;
      idx_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (push.vld) begin
        wp_r <= wp_r + QAW'(1);
      end
      if (pop) begin
        rp_r  <= rp_r + QAW'(1);
        idx_r <= '0;
      end else if (step) begin
        idx_r <= idx_r + 2'd1;
      end
      cnt_r <= cnt_r + (QAW+1)'(push.vld) - (QAW+1)'(pop);
      if (load_out) begin
        out_vld_r <= (cnt_r != '0);
      end
    end
  end

  assign out_valid   = out_vld_r;
  assign out_pixel_x = px_r;
  assign out_pixel_y = py_r;
  assign out_color   = col_r;
  assign out_last    = last_r;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QAW+1)'(QDEPTH))
    else $error("queue count past depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.vld |-> !q_full)
    else $error("push into full queue");

  a_idx_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) |-> (idx_r <= nlast))
    else $error("pixel index past end of burst");

  a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (out_valid && out_last))
    else $error("burst end without last flag");
`endif

endmodule

>>> hdl/rain_snow_particle_projector.sv
// most of the input-to-output latency lies in the 32-stage dividers
// throughput: one item per cycle while in_stall is low; a point gives up to
// four pixels, one per cycle while out_stall is low, paced by the output emitter
// reset: synchronous, active low; clears pipeline valids, queue and output,
// and loads configuration defaults; the wall-height store is not cleared
// ----------------------------------------------------------------------------
// rain_snow_particle_projector
// Projects rain and snow particles to pixel writes with wall occlusion.
// ----------------------------------------------------------------------------
module rain_snow_particle_projector import rsp_pkg::*; #(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_mode,
  input  logic [9:0]       in_column,
  input  logic [14:0]      in_wall_height,
  input  logic [13:0]      in_point_x_low,
  input  logic [13:0]      in_point_z_low,
  input  logic [9:0]       in_point_y_low,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [9:0]       out_pixel_x,
  output logic [9:0]       out_pixel_y,
  output logic [4:0]       out_color,
  output logic             out_last
);

  q_push_t push;
  logic    q_full;

  rsp_front #(.MAX_COLUMNS(MAX_COLUMNS)) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_mode(in_mode),
    .in_column(in_column),
    .in_wall_height(in_wall_height),
    .in_point_x_low(in_point_x_low),
    .in_point_z_low(in_point_z_low),
    .in_point_y_low(in_point_y_low),
    .q_full(q_full),
    .push(push)
  );

  rsp_back u_back (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .q_full(q_full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_pixel_x(out_pixel_x),
    .out_pixel_y(out_pixel_y),
    .out_color(out_color),
    .out_last(out_last)
  );

  assign in_stall = q_full;

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives rain, snow and wall-load items into the particle projector under
// several register settings, with random idling on both channels, and checks
// every pixel write against an in-bench projection or directed expectations.
// ----------------------------------------------------------------------------
module testbench;
  import rsp_pkg::*;

  typedef struct packed {
    logic [9:0] x;
    logic [9:0] y;
    logic [4:0] c;
    logic       l;
  } pixel_t;

  typedef struct {
    logic [1:0]  mode;
    logic [9:0]  col;
    logic [14:0] wall;
    logic [13:0] px;
    logic [13:0] pz;
    logic [9:0]  py;
    int          nexp;
    pixel_t      e0, e1, e2, e3;
  } row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [2:0]       cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       in_mode = '0;
  logic [9:0]       in_column = '0;
  logic [14:0]      in_wall_height = '0;
  logic [13:0]      in_point_x_low = '0;
  logic [13:0]      in_point_z_low = '0;
  logic [9:0]       in_point_y_low = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [9:0]       out_pixel_x;
  logic [9:0]       out_pixel_y;
  logic [4:0]       out_color;
  logic             out_last;

  // shadow registers and wall store
  logic [13:0] cam_x = '0;
  logic [13:0] cam_z = '0;
  logic [17:0] view_cos = 18'd65536;
  logic [17:0] view_sin = '0;
  logic [15:0] fall = '0;
  logic [20:0] hnum = '0;
  logic [10:0] view_w = 11'd320;
  logic [10:0] view_h = 11'd160;
  logic [15:0] wall_mem [1024];
  bit          wall_set [1024];

  pixel_t pending_pixels[$];
  int     errors = 0;
  bit     quiet = 1'b0;
  int     ostall_cnt = 0;

  rain_snow_particle_projector i_dut (.*);

  always #5 clk = ~clk;

  function automatic pixel_t mk(input longint x, input longint y, input longint c);
    pixel_t p;
    p.x = x[9:0];
    p.y = y[9:0];
    p.c = c[4:0];
    p.l = 1'b0;
    return p;
  endfunction

  function automatic int project_point(input logic [1:0] md, input logic [13:0] px,
                                       input logic [13:0] pz, input logic [9:0] py,
                                       output pixel_t pix[4], output int col);
    logic [13:0] sx, sz;
    logic [15:0] fy;
    longint cs, sn, ax, az, x, y, w, z, shade, xx, yy, act, height, wh, vw, vh;
    int n;
    n = 0;
    col = -1;
    for (int i = 0; i < 4; i++) pix[i] = '0;
    if (md != MODE_RAIN && md != MODE_SNOW) return 0;
    vw = longint'(view_w);
    vh = longint'(view_h);
    cs = longint'($signed(view_cos));
    sn = longint'($signed(view_sin));
    sx = px + cam_x;
    sz = pz + cam_z;
    ax = 64'sd8191 - longint'(sx);
    az = 64'sd8191 - longint'(sz);
    x = ax * cs + az * sn;
    x = longint'($signed(x[31:0]));
    w = az * cs - ax * sn;
    w = longint'($signed(w[31:0]));
    fy = {py, 6'b0} + fall;
    y = -(longint'(hnum) <<< 7) + (longint'(fy) <<< 11);
    if (w < 256) return 0;
    z = w / 256;
    shade = z / 131072;
    if (shade > 13) return 0;
    xx = x / z + vw / 2;
    if (xx < 0 || xx >= vw) return 0;
    act = y / z;
    yy = vh / 2 - act;
    height = (longint'(hnum) <<< 10) / z;
    if (act < 0) act = -act;
    wh = 0;
    if (xx < 1024) begin
      col = int'(xx);
      wh = wall_set[xx] ? longint'(wall_mem[xx]) : 0;
    end
    if (act < wh / 8 && height < wh) return 0;
    if (yy <= 0 || yy >= vh) return 0;
    if (md == MODE_RAIN) begin
      pix[n++] = mk(xx, yy, shade + 15);
      pix[n++] = mk(xx, yy - 1, shade + 16);
      if (yy > 2) pix[n++] = mk(xx, yy - 2, shade + 17);
    end else begin
      if (xx <= 0) return 0;
      if (shade < 10) begin
        pix[n++] = mk(xx, yy, shade + 17);
        pix[n++] = mk(xx - 1, yy, shade + 16);
        pix[n++] = mk(xx, yy - 1, shade + 16);
        pix[n++] = mk(xx - 1, yy - 1, shade + 15);
      end else begin
        pix[n++] = mk(xx, yy, shade + 15);
      end
    end
    pix[n-1].l = 1'b1;
    return n;
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_CAM_X:      cam_x = val[13:0];
      CFG_CAM_Z:      cam_z = val[13:0];
      CFG_VIEW_COS:   view_cos = val[17:0];
      CFG_VIEW_SIN:   view_sin = val[17:0];
      CFG_FALL:       fall = val[15:0];
      CFG_HEIGHT_NUM: hnum = val[20:0];
      CFG_VIEW_W:     view_w = val[10:0];
      CFG_VIEW_H:     view_h = val[10:0];
      default: ;
    endcase
  endtask

  // present one item and return at the edge that accepts it
  task automatic drive_item(input logic [1:0] md, input logic [9:0] col,
                            input logic [14:0] wall, input logic [13:0] px,
                            input logic [13:0] pz, input logic [9:0] py);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= md;
    in_column <= col;
    in_wall_height <= wall;
    in_point_x_low <= px;
    in_point_z_low <= pz;
    in_point_y_low <= py;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    if (md == MODE_LOAD) begin
      wall_mem[col] = {1'b0, wall};
      wall_set[col] = 1'b1;
    end
  endtask

  task automatic issue(input row_t r);
    pixel_t pix[4];
    int     n, col;
    n = project_point(r.mode, r.px, r.pz, r.py, pix, col);
    if (col >= 0 && !wall_set[col]) begin
      drive_item(MODE_LOAD, col[9:0], 15'($urandom_range(0, 400)), '0, '0, '0);
      n = project_point(r.mode, r.px, r.pz, r.py, pix, col);
    end
    drive_item(r.mode, r.col, r.wall, r.px, r.pz, r.py);
    if (r.nexp >= 0) begin
      n = r.nexp;
      pix[0] = r.e0;
      pix[1] = r.e1;
      pix[2] = r.e2;
      pix[3] = r.e3;
    end
    for (int i = 0; i < n; i++) pending_pixels.push_back(pix[i]);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic row_t rand_row;
    row_t r;
    int   k, az;
    r = '{default: '0};
    r.nexp = -1;
    k = $urandom_range(0, 9);
    r.mode = (k == 0) ? 2'd3 : (k < 3) ? MODE_LOAD : (k < 6) ? MODE_RAIN : MODE_SNOW;
    r.col = 10'($urandom);
    r.wall = ($urandom_range(0, 1)) ? 15'($urandom) : 15'($urandom_range(0, 300));
    r.px = 14'($urandom);
    r.pz = 14'($urandom);
    r.py = 10'($urandom);
    if ($urandom_range(0, 3) != 0) begin
      az = $urandom_range(1, 7000);
      r.pz = 14'(8191 - az - int'(cam_z));
      r.px = 14'(8191 - int'(cam_x) + $urandom_range(0, 400) - 200);
    end
    if ($urandom_range(0, 1)) r.py = 10'($urandom_range(0, 40));
    return r;
  endfunction

  // output side stall bursts
  always @(posedge clk) begin
    if (quiet) begin
      out_stall <= 1'b0;
    end else if (ostall_cnt > 0) begin
      ostall_cnt <= ostall_cnt - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      ostall_cnt <= $urandom_range(0, 14);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // pixel checker
  always @(negedge clk) begin
    pixel_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel x=%0d y=%0d color=%0d last=%0d", $time,
                 out_pixel_x, out_pixel_y, out_color, out_last);
        errors++;
      end else begin
        e = pending_pixels.pop_front();
        if (out_pixel_x !== e.x) begin
          $display("%0t: pixel_x expected %0d actual %0d", $time, e.x, out_pixel_x);
          errors++;
        end
        if (out_pixel_y !== e.y) begin
          $display("%0t: pixel_y expected %0d actual %0d", $time, e.y, out_pixel_y);
          errors++;
        end
        if (out_color !== e.c) begin
          $display("%0t: color expected %0d actual %0d", $time, e.c, out_color);
          errors++;
        end
        if (out_last !== e.l) begin
          $display("%0t: last expected %0d actual %0d", $time, e.l, out_last);
          errors++;
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    row_t        dir_tab[$];
    row_t        r;
    logic [20:0] ph [6][8];
    int          items;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults after reset: horizon row 80, center column 160
    dir_tab.push_back('{MODE_LOAD, 10'd160, 15'd0, 0, 0, 0, 0, '0, '0, '0, '0});
    dir_tab.push_back('{MODE_LOAD, 10'd1023, 15'd32767, 14'h3fff, 14'h3fff, 10'h3ff, 0,
                        '0, '0, '0, '0});
    dir_tab.push_back('{MODE_RAIN, 0, 0, 14'd8191, 14'd7167, 0, 3,
                        {10'd160, 10'd80, 5'd17, 1'b0}, {10'd160, 10'd79, 5'd18, 1'b0},
                        {10'd160, 10'd78, 5'd19, 1'b1}, '0});
    dir_tab.push_back('{MODE_SNOW, 0, 0, 14'd8191, 14'd7167, 0, 4,
                        {10'd160, 10'd80, 5'd19, 1'b0}, {10'd159, 10'd80, 5'd18, 1'b0},
                        {10'd160, 10'd79, 5'd18, 1'b0}, {10'd159, 10'd79, 5'd17, 1'b1}});
    dir_tab.push_back('{2'd3, 10'h3ff, 15'h7fff, 14'd8191, 14'd7167, 10'h3ff, 0,
                        '0, '0, '0, '0});
    // zero depth and too far
    dir_tab.push_back('{MODE_RAIN, 0, 0, 14'd8191, 14'd8191, 0, 0, '0, '0, '0, '0});
    dir_tab.push_back('{MODE_RAIN, 0, 0, 14'd8191, 14'd0, 0, 0, '0, '0, '0, '0});
    dir_tab.push_back('{MODE_RAIN, 0, 0, 14'd8191, 14'd1023, 0, 0, '0, '0, '0, '0});
    // farthest shade for rain, far snow gives a single pixel
    dir_tab.push_back('{MODE_RAIN, 0, 0, 14'd8191, 14'd1535, 0, 3,
                        {10'd160, 10'd80, 5'd28, 1'b0}, {10'd160, 10'd79, 5'd29, 1'b0},
                        {10'd160, 10'd78, 5'd30, 1'b1}, '0});
    dir_tab.push_back('{MODE_SNOW, 0, 0, 14'd8191, 14'd3071, 0, 1,
                        {10'd160, 10'd80, 5'd25, 1'b1}, '0, '0, '0});
    // hidden behind a tall wall
    dir_tab.push_back('{MODE_LOAD, 10'd160, 15'd32767, 0, 0, 0, 0, '0, '0, '0, '0});
    dir_tab.push_back('{MODE_RAIN, 0, 0, 14'd8191, 14'd7167, 0, 0, '0, '0, '0, '0});
    dir_tab.push_back('{MODE_LOAD, 10'd160, 15'd0, 0, 0, 0, 0, '0, '0, '0, '0});
    dir_tab.push_back('{MODE_RAIN, 0, 0, 14'd0, 14'd7167, 10'h3ff, -1, '0, '0, '0, '0});
    dir_tab.push_back('{MODE_SNOW, 0, 0, 14'h3fff, 14'h3fff, 10'h3ff, -1, '0, '0, '0, '0});
    dir_tab.push_back('{MODE_RAIN, 0, 0, 14'd8191, 14'd6000, 10'd512, -1, '0, '0, '0, '0});
    dir_tab.push_back('{MODE_SNOW, 0, 0, 14'd8100, 14'd7600, 10'd5, -1, '0, '0, '0, '0});
    dir_tab.push_back('{MODE_RAIN, 0, 0, 14'd8191, 14'd8190, 0, -1, '0, '0, '0, '0});
    foreach (dir_tab[i]) issue(dir_tab[i]);
    drain();

    // cam_x, cam_z, cos, sin, fall, height numerator, width, height
    ph[0] = '{21'd16383, 21'd16383, -21'sd65536, 21'd0, 21'd65535, 21'd2097151,
              21'd1024, 21'd1024};
    ph[1] = '{21'd0, 21'd0, 21'd0, 21'd65536, 21'd0, 21'd0, 21'd1, 21'd2};
    ph[2] = '{21'd100, 21'd9000, 21'd46341, -21'sd46341, 21'd777, 21'd300, 21'd640, 21'd480};
    ph[3] = '{21'($urandom_range(0, 16383)), 21'($urandom_range(0, 16383)),
              21'($urandom_range(0, 131072) - 65536), 21'($urandom_range(0, 131072) - 65536),
              21'($urandom_range(0, 65535)), 21'($urandom_range(0, 4000)),
              21'($urandom_range(1, 1024)), 21'($urandom_range(2, 1024))};
    ph[4] = '{21'd0, 21'd0, 21'd65536, 21'd0, 21'd1234, 21'd1000, 21'd320, 21'd160};
    ph[5] = '{21'd37, 21'd5000, 21'd60000, 21'd25000, 21'd0, 21'd200, 21'd1024, 21'd1024};
    items = 0;
    for (int p = 0; p < 6; p++) begin
      for (int k = 0; k < 8; k++) write_reg(cfg_idx_t'(k), ph[p][k]);
      cfg_we <= 1'b0;
      if (p == 5) quiet = 1'b1;
      for (int i = 0; i < 15; i++) begin
        r = rand_row();
        issue(r);
        items++;
        if (items == 40) begin
          in_valid <= 1'b0;
          while (pending_pixels.size() != 0) @(posedge clk);
          @(posedge clk);
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/rsp_pkg.sv
hdl/rsp_ram.sv
hdl/rsp_div.sv
hdl/rsp_front.sv
hdl/rsp_back.sv
hdl/rain_snow_particle_projector.sv
bench/testbench.sv
